@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define DFX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DFX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dfx_pkg.sv @@
// Types and constants of the byte-stuffing deframer.
`timescale 1ns / 1ps
package dfx_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_FLAG = 3'd1,
    ST_ADDR = 3'd2,
    ST_CTRL = 3'd3,
    ST_DATA = 3'd4,
    ST_ESC  = 3'd5
  } state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_DISC    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_FLAG   = 3'd0,
    REG_ESCAPE = 3'd1,
    REG_ADDR   = 3'd2,
    REG_INFO0  = 3'd3,
    REG_INFO1  = 3'd4,
    REG_DISC   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] address_byte;
    logic [7:0] info_code_zero;
    logic [7:0] info_code_one;
    logic [7:0] disconnect_code;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       seq;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ hw/rtl/dfx_front.sv @@
// Front end: header parser and destuffer, emits up to two results per byte.
`timescale 1ns / 1ps
module dfx_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  dfx_pkg::cfg_t cfg,
  output dfx_pkg::push_t push
);
  import dfx_pkg::*;

  state_t     state, state_next;
  logic [7:0] control_seen, control_seen_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic [7:0] running_xor, running_xor_next;
  logic       expected_sequence, expected_sequence_next;

  logic is_flag, is_esc, is_info, hdr_ok;
  result_t r0, r1;
  logic [1:0] n;

  assign is_flag = (rx_byte == cfg.flag_byte);
  assign is_esc  = (rx_byte == cfg.escape_byte);
  assign is_info = (rx_byte == cfg.info_code_zero) || (rx_byte == cfg.info_code_one);
  assign hdr_ok  = (rx_byte == (cfg.address_byte ^ control_seen));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_HUNT: if (is_flag) state_next = ST_FLAG;
      ST_FLAG: begin
        if (rx_byte == cfg.address_byte) state_next = ST_ADDR;
        else if (!is_flag) state_next = ST_HUNT;
      end
      ST_ADDR: begin
        if (is_info) state_next = ST_CTRL;
        else if (is_flag) state_next = ST_FLAG;
        else state_next = ST_HUNT;
      end
      ST_CTRL: begin
        if (hdr_ok) state_next = ST_DATA;
        else if (is_flag) state_next = ST_FLAG;
        else state_next = ST_HUNT;
      end
      ST_DATA: begin
        if (is_esc) state_next = ST_ESC;
        else if (is_flag) state_next = held_valid ? ST_HUNT : ST_FLAG;
      end
      ST_ESC:  state_next = ST_DATA;
      default: state_next = ST_HUNT;
    endcase
  end

  // results and datapath
  always_comb begin
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    control_seen_next      = control_seen;
    held_byte_next         = held_byte;
    held_valid_next        = held_valid;
    running_xor_next       = running_xor;
    expected_sequence_next = expected_sequence;
    unique case (state)
      ST_ADDR: begin
        if (is_info) control_seen_next = rx_byte;
        else if (!is_flag && rx_byte == cfg.disconnect_code) begin
          n = 2'd1;
          r0.kind = KIND_DISC;
        end
      end
      ST_CTRL: begin
        if (hdr_ok) begin
          held_valid_next  = 1'b0;
          held_byte_next   = '0;
          running_xor_next = '0;
        end
      end
      ST_DATA: begin
        if (is_esc) begin
        end else if (is_flag) begin
          if (held_valid) begin
            n = 2'd1;
            r0.seq = expected_sequence;
            if (held_byte == running_xor) begin
              r0.kind = KIND_GOOD;
              expected_sequence_next = ~expected_sequence;
            end else begin
              r0.kind = KIND_BAD;
            end
            held_valid_next = 1'b0;
          end
        end else begin
          if (held_valid) begin
            n = 2'd1;
            r0.payload = held_byte;
            running_xor_next = running_xor ^ held_byte;
          end
          held_byte_next  = rx_byte;
          held_valid_next = 1'b1;
        end
      end
      ST_ESC: begin
        held_byte_next  = rx_byte;
        held_valid_next = 1'b1;
        if (is_esc || is_flag) begin
          if (held_valid) begin
            n = 2'd1;
            r0.payload = held_byte;
            running_xor_next = running_xor ^ held_byte;
          end
        end else if (held_valid) begin
          n = 2'd2;
          r0.payload = held_byte;
          r1.payload = cfg.escape_byte;
          running_xor_next = running_xor ^ held_byte ^ cfg.escape_byte;
        end else begin
          n = 2'd1;
          r0.payload = cfg.escape_byte;
          running_xor_next = running_xor ^ cfg.escape_byte;
        end
      end
      default: begin
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = (n == 2'd2);
  end

  assign push.n  = accept ? n : 2'd0;
  assign push.r0 = r0;
  assign push.r1 = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_HUNT;
      control_seen      <= '0;
      held_byte         <= '0;
      held_valid        <= 1'b0;
      running_xor       <= '0;
      expected_sequence <= 1'b1;
    end else if (accept) begin
      state             <= state_next;
      control_seen      <= control_seen_next;
      held_byte         <= held_byte_next;
      held_valid        <= held_valid_next;
      running_xor       <= running_xor_next;
      expected_sequence <= expected_sequence_next;
    end
  end

endmodule

@@ hw/rtl/dfx_queue.sv @@
// Result queue between front and back: two writes, one read per cycle.
`timescale 1ns / 1ps
module dfx_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  dfx_pkg::push_t         push,
  input  logic                   pop,
  output dfx_pkg::result_t       head,
  output logic [dfx_pkg::QCntW-1:0] count
);
  import dfx_pkg::*;

  result_t          slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr, wr_ptr_inc;

  assign wr_ptr_inc = wr_ptr + QPtrW'(1);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slots[wr_ptr] <= push.r0;
    if (push.n == 2'd2) slots[wr_ptr_inc] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push.n);
      if (pop) rd_ptr <= rd_ptr + QPtrW'(1);
      count <= count + QCntW'(push.n) - QCntW'(pop);
    end
  end

endmodule

@@ hw/rtl/dfx_back.sv @@
// Back end: output register that drains the result queue.
`timescale 1ns / 1ps
module dfx_back (
  input  logic                      clk,
  input  logic                      rst,
  input  dfx_pkg::result_t          head,
  input  logic [dfx_pkg::QCntW-1:0] count,
  output logic                      pop,
  input  logic                      out_stall,
  output logic                      out_valid,
  output dfx_pkg::result_t          out_res
);
  import dfx_pkg::*;

  assign pop = (count != '0) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_res <= head;
  end

endmodule

@@ hw/rtl/byte_stuffing_deframer_xor_check_core.sv @@
// Top level of the byte-stuffing deframer with XOR checks.
//
//   channel  direction  handshake            payload
//   rx       in         in_valid / in_stall  rx_byte
//   result   out        out_valid/out_stall  kind, payload_byte, ack_sequence, last
//   config   in         APB psel/penable     paddr, pwdata, prdata
//
// The parser takes one byte per cycle while in_stall is low and writes its 0 to 2
// results into a 4-entry queue; the output register drains one result per cycle
// while out_stall does not hold it.
// in_stall rises while the queue holds more than 2 results.
// Reset is synchronous; registers return to their defaults, queue empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module byte_stuffing_deframer_xor_check_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        ack_sequence,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dfx_pkg::*;

  cfg_t             cfg;
  push_t            push;
  result_t          head, out_res;
  logic [QCntW-1:0] q_count;
  logic             pop, accept, cfg_wr;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte       <= 8'd126;
      cfg.escape_byte     <= 8'd125;
      cfg.address_byte    <= 8'd3;
      cfg.info_code_zero  <= 8'd0;
      cfg.info_code_one   <= 8'd64;
      cfg.disconnect_code <= 8'd11;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FLAG:   cfg.flag_byte       <= pwdata[7:0];
        REG_ESCAPE: cfg.escape_byte     <= pwdata[7:0];
        REG_ADDR:   cfg.address_byte    <= pwdata[7:0];
        REG_INFO0:  cfg.info_code_zero  <= pwdata[7:0];
        REG_INFO1:  cfg.info_code_one   <= pwdata[7:0];
        REG_DISC:   cfg.disconnect_code <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLAG:   prdata = {24'd0, cfg.flag_byte};
      REG_ESCAPE: prdata = {24'd0, cfg.escape_byte};
      REG_ADDR:   prdata = {24'd0, cfg.address_byte};
      REG_INFO0:  prdata = {24'd0, cfg.info_code_zero};
      REG_INFO1:  prdata = {24'd0, cfg.info_code_one};
      REG_DISC:   prdata = {24'd0, cfg.disconnect_code};
      default:    prdata = '0;
    endcase
  end

  assign in_stall = (q_count > QCntW'(QDepth - 2));
  assign accept   = in_valid && !in_stall;

  dfx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .push    (push)
  );

  dfx_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  dfx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .count     (q_count),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload;
  assign ack_sequence = out_res.seq;
  assign last         = out_res.last;

  `DFX_ASSERT(a_q_bound, q_count <= QCntW'(QDepth), "queue overfilled")
  `DFX_ASSERT(a_room, !in_stall |-> (q_count <= QCntW'(QDepth - 2)), "no room for transaction")
  `DFX_ASSERT(a_no_push_stalled, in_stall |-> (push.n == 2'd0), "push while stalled")
  `DFX_ASSERT(a_pop_nonempty, pop |-> (q_count != '0), "pop from empty queue")
  `DFX_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid, "output valid after reset")

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the byte-stuffing deframer: directed frames, register sweeps, random traffic.
`timescale 1ns / 1ps
module testbench;
  import dfx_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        ack_sequence;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  byte_stuffing_deframer_xor_check_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .payload_byte(payload_byte), .ack_sequence(ack_sequence), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the register file and the parser state
  cfg_t       regs;
  state_t     parse_st;
  logic [7:0] ctrl_byte;
  logic [7:0] held;
  logic       held_ok;
  logic [7:0] run_xor;
  logic       ack_seq;

  result_t expected_results[$];
  result_t step_res[$];
  int      fail_count;
  int      items_sent;
  bit      idling;
  int      hold_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall = 1'b0;
      end else begin
        out_stall = idling && ($urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d payload %0h", kind, payload_byte);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_count++;
        end
        if (payload_byte !== want.payload) begin
          $error("payload_byte: expected %0h, got %0h", want.payload, payload_byte);
          fail_count++;
        end
        if (ack_sequence !== want.seq) begin
          $error("ack_sequence: expected %0d, got %0d", want.seq, ack_sequence);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  function automatic result_t make_result(kind_t k, logic [7:0] p, logic s);
    return '{kind: k, payload: p, seq: s, last: 1'b0};
  endfunction

  function automatic void release_payload(logic [7:0] b);
    if (held_ok) begin
      step_res.push_back(make_result(KIND_PAYLOAD, held, 1'b0));
      run_xor = run_xor ^ held;
    end
    held    = b;
    held_ok = 1'b1;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    step_res.delete();
    case (parse_st)
      ST_HUNT: begin
        if (b == regs.flag_byte) parse_st = ST_FLAG;
      end
      ST_FLAG: begin
        if (b == regs.address_byte) parse_st = ST_ADDR;
        else if (b != regs.flag_byte) parse_st = ST_HUNT;
      end
      ST_ADDR: begin
        if (b == regs.info_code_zero || b == regs.info_code_one) begin
          ctrl_byte = b;
          parse_st  = ST_CTRL;
        end else if (b == regs.flag_byte) begin
          parse_st = ST_FLAG;
        end else if (b == regs.disconnect_code) begin
          step_res.push_back(make_result(KIND_DISC, 8'h00, 1'b0));
          parse_st = ST_HUNT;
        end else begin
          parse_st = ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (b == (regs.address_byte ^ ctrl_byte)) begin
          parse_st = ST_DATA;
          held_ok  = 1'b0;
          held     = 8'h00;
          run_xor  = 8'h00;
        end else if (b == regs.flag_byte) begin
          parse_st = ST_FLAG;
        end else begin
          parse_st = ST_HUNT;
        end
      end
      ST_DATA: begin
        if (b == regs.escape_byte) begin
          parse_st = ST_ESC;
        end else if (b == regs.flag_byte) begin
          if (!held_ok) begin
            parse_st = ST_FLAG;
          end else begin
            if (held == run_xor) begin
              step_res.push_back(make_result(KIND_GOOD, 8'h00, ack_seq));
              ack_seq = ~ack_seq;
            end else begin
              step_res.push_back(make_result(KIND_BAD, 8'h00, ack_seq));
            end
            held_ok  = 1'b0;
            parse_st = ST_HUNT;
          end
        end else begin
          release_payload(b);
        end
      end
      ST_ESC: begin
        parse_st = ST_DATA;
        if (b == regs.escape_byte || b == regs.flag_byte) begin
          release_payload(b);
        end else begin
          release_payload(regs.escape_byte);
          release_payload(b);
        end
      end
      default: parse_st = ST_HUNT;
    endcase
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) expected_results.push_back(step_res[i]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (idling && $urandom_range(0, 99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'h0, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_FLAG:   regs.flag_byte       = v;
      REG_ESCAPE: regs.escape_byte     = v;
      REG_ADDR:   regs.address_byte    = v;
      REG_INFO0:  regs.info_code_zero  = v;
      REG_INFO1:  regs.info_code_one   = v;
      REG_DISC:   regs.disconnect_code = v;
      default: ;
    endcase
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_FLAG, c.flag_byte);
    write_reg(REG_ESCAPE, c.escape_byte);
    write_reg(REG_ADDR, c.address_byte);
    write_reg(REG_INFO0, c.info_code_zero);
    write_reg(REG_INFO1, c.info_code_one);
    write_reg(REG_DISC, c.disconnect_code);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return regs.flag_byte;
      1: return regs.escape_byte;
      2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // header, stuffed body with XOR check, closing flag
  task automatic send_frame(input logic [7:0] ctrl, input int len, input bit corrupt,
                            input bit loose);
    logic [7:0] body[$];
    logic [7:0] chk;
    logic [7:0] b;
    chk = 8'h00;
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      body.push_back(b);
      chk = chk ^ b;
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    body.push_back(chk);
    send_byte(regs.flag_byte);
    send_byte(regs.address_byte);
    send_byte(ctrl);
    send_byte(regs.address_byte ^ ctrl);
    foreach (body[i]) begin
      if (body[i] == regs.flag_byte || body[i] == regs.escape_byte) begin
        if (loose && body[i] == regs.escape_byte && i + 1 < body.size() &&
            body[i + 1] != regs.flag_byte && body[i + 1] != regs.escape_byte) begin
          send_byte(body[i]);
        end else begin
          send_byte(regs.escape_byte);
          send_byte(body[i]);
        end
      end else begin
        send_byte(body[i]);
      end
    end
    send_byte(regs.flag_byte);
  endtask

  function automatic logic [7:0] pick_ctrl();
    return $urandom_range(0, 1) ? regs.info_code_one : regs.info_code_zero;
  endfunction

  task automatic random_traffic(input int n_items);
    int counted;
    int start;
    int pick;
    int len;
    logic [7:0] ctrl;
    counted = 0;
    while (counted < n_items) begin
      pick  = $urandom_range(0, 99);
      start = items_sent;
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        send_frame(pick_ctrl(), len, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
      end else if (pick < 78) begin
        send_byte(regs.flag_byte);
        send_byte(regs.address_byte);
        send_byte(regs.disconnect_code);
      end else if (pick < 90) begin
        send_byte(regs.flag_byte);
        ctrl = pick_ctrl();
        case ($urandom_range(0, 3))
          0: send_byte(pick_byte());
          1: begin
            send_byte(regs.address_byte);
            send_byte(pick_byte());
          end
          2: begin
            send_byte(regs.address_byte);
            send_byte(ctrl);
            send_byte(regs.address_byte ^ ctrl ^ 8'($urandom_range(1, 255)));
          end
          default: begin
            send_byte(regs.address_byte);
            send_byte(regs.flag_byte);
          end
        endcase
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
      counted += items_sent - start;
    end
  endtask

  task automatic test_disconnect();
    send_byte(8'h7E);
    send_byte(8'h03);
    send_byte(8'h0B);
  endtask

  task automatic test_empty_close();
    // flag straight after the header reopens; then a frame with an empty payload
    send_byte(8'h7E);
    send_byte(8'h03);
    send_byte(8'h40);
    send_byte(8'h43);
    send_byte(8'h7E);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'h7E);
  endtask

  task automatic test_escapes_bad_check();
    // escaped flag, escape before an ordinary byte, wrong check
    send_byte(8'h7E);
    send_byte(8'h03);
    send_byte(8'h40);
    send_byte(8'h43);
    send_byte(8'h7D);
    send_byte(8'h7E);
    send_byte(8'h7D);
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h7E);
  endtask

  task automatic test_random_defaults();
    random_traffic(70);
  endtask

  task automatic test_no_idling();
    idling = 1'b0;
    random_traffic(60);
    idling = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (3) send_frame(pick_ctrl(), 15, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) send_frame(pick_ctrl(), $urandom_range(0, 6), 1'b0, 1'b0);
    wait_drained();
    random_traffic(30);
  endtask

  task automatic test_extreme_regs();
    load_regs('{flag_byte: 8'h00, escape_byte: 8'hFF, address_byte: 8'hFF,
                info_code_zero: 8'h00, info_code_one: 8'hFF, disconnect_code: 8'h80});
    random_traffic(50);
    load_regs('{flag_byte: 8'hFF, escape_byte: 8'h00, address_byte: 8'h00,
                info_code_zero: 8'hFF, info_code_one: 8'h01, disconnect_code: 8'hFE});
    random_traffic(50);
  endtask

  task automatic test_random_regs();
    cfg_t c;
    c.flag_byte       = 8'($urandom);
    c.escape_byte     = 8'($urandom);
    c.address_byte    = 8'($urandom);
    c.info_code_zero  = 8'($urandom);
    c.info_code_one   = 8'($urandom);
    c.disconnect_code = 8'($urandom);
    load_regs(c);
    random_traffic(70);
  endtask

  task automatic test_escape_is_flag();
    write_reg(REG_ESCAPE, regs.flag_byte);
    random_traffic(40);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    items_sent  = 0;
    idling      = 1'b1;
    hold_cycles = 0;
    regs        = '{flag_byte: 8'd126, escape_byte: 8'd125, address_byte: 8'd3,
                    info_code_zero: 8'd0, info_code_one: 8'd64, disconnect_code: 8'd11};
    parse_st    = ST_HUNT;
    ctrl_byte   = 8'h00;
    held        = 8'h00;
    held_ok     = 1'b0;
    run_xor     = 8'h00;
    ack_seq     = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_disconnect();
    test_empty_close();
    test_escapes_bad_check();
    test_random_defaults();
    test_no_idling();
    test_backpressure();
    test_drain_pause();
    test_extreme_regs();
    test_random_regs();
    test_escape_is_flag();

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dfx_pkg.sv
hw/rtl/dfx_front.sv
hw/rtl/dfx_queue.sv
hw/rtl/dfx_back.sv
hw/rtl/byte_stuffing_deframer_xor_check_core.sv
dv/testbench.sv
